### rtl/core/idb_pkg.sv
// Shared constants, types, coefficient tables and fixed-point helpers of the IIR decimator.
package idb_pkg;

    localparam int MAX_SECTIONS = 9;
    localparam int CHANNELS     = 2;
    localparam int SAMPLE_BITS  = 24;

    localparam int COEF_W     = 32;
    localparam int COEF_SHIFT = 28;
    localparam int MEM_W      = 48;
    // mulq result: 48-bit state times 32-bit coefficient, scaled down by 2^28
    localparam int PROD_W     = MEM_W + COEF_W - COEF_SHIFT;
    // recursion partial sums: input plus bias minus up to two products
    localparam int T_W        = PROD_W + 2;
    localparam int XB_W       = SAMPLE_BITS + 2;
    localparam int ACC_W      = PROD_W + $clog2(2 * MAX_SECTIONS + 1);

    localparam int ROWS  = MAX_SECTIONS * CHANNELS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int SEC_W = $clog2(MAX_SECTIONS);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int FAST_LEN   = 4;
    localparam int BEST_LEN   = 9;
    localparam int FAST_IDX_W = $clog2(FAST_LEN);
    localparam int BEST_IDX_W = $clog2(BEST_LEN);
    localparam int FAST_USED  = (FAST_LEN < MAX_SECTIONS) ? FAST_LEN : MAX_SECTIONS;
    localparam int BEST_USED  = (BEST_LEN < MAX_SECTIONS) ? BEST_LEN : MAX_SECTIONS;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SAMPLE_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 1'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]      coef_word_t;
    typedef logic signed [MEM_W-1:0]       mem_word_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    typedef struct packed {
        coef_word_t num1;
        coef_word_t num2;
        coef_word_t den1;
        coef_word_t den2;
    } coef_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic             clear;
    } mem_req_t;

    // Q3.28 from a decimal scaled by 1e9, rounded half away from zero
    function automatic coef_word_t cq(input longint n);
        longint r;
        r = (n * 64'sd268435456 + ((n < 0) ? -64'sd500000000 : 64'sd500000000))
            / 64'sd1000000000;
        return COEF_W'(r);
    endfunction

    localparam coef_word_t GAIN_FAST = cq(64'sd882838);
    localparam coef_word_t GAIN_BEST = cq(64'sd1431379);

    localparam coef_t TABLE_FAST [FAST_LEN] = '{
        '{cq(64'sd1215377077), cq(-64'sd358644550), cq(-64'sd972220719), cq(64'sd252934736)},
        '{cq(-64'sd1525654419), cq(64'sd867849186), cq(-64'sd977713689), cq(64'sd376580617)},
        '{cq(64'sd136094442), cq(-64'sd504141168), cq(-64'sd1007004472), cq(64'sd584048855)},
        '{cq(64'sd180604082), cq(-64'sd4676243), cq(-64'sd1093486919), cq(64'sd844904525)}
    };

    localparam coef_t TABLE_BEST [BEST_LEN] = '{
        '{cq(64'sd2858003567), cq(-64'sd260734268), cq(-64'sd602478422), cq(64'sd109823443)},
        '{cq(-64'sd4395194084), cq(64'sd1465197533), cq(-64'sd533817668), cq(64'sd226045922)},
        '{cq(64'sd866385507), cq(-64'sd2105385142), cq(-64'sd429134968), cq(64'sd403512574)},
        '{cq(64'sd1671614855), cq(64'sd796359588), cq(-64'sd324989203), cq(64'sd580756667)},
        '{cq(-64'sd1199627593), cq(64'sd587359518), cq(-64'sd241486447), cq(64'sd724264900)},
        '{cq(64'sd16317799), cq(-64'sd628233474), cq(-64'sd182766026), cq(64'sd827774002)},
        '{cq(64'sd284044159), cq(64'sd103862000), cq(-64'sd145276650), cq(64'sd898510502)},
        '{cq(-64'sd81057884), cq(64'sd78155158), cq(-64'sd123965847), cq(64'sd947105258)},
        '{cq(-64'sd8726089), cq(-64'sd22209823), cq(-64'sd115056854), cq(64'sd983542001)}
    };

    function automatic coef_t coef_rom(input logic quality, input logic [SEC_W-1:0] sec);
        coef_t k;
        if (quality)
        begin
            k = TABLE_BEST[BEST_IDX_W'(sec)];
        end
        else
        begin
            k = TABLE_FAST[FAST_IDX_W'(sec)];
        end
        return k;
    endfunction

    function automatic mem_word_t sat_mem(input logic signed [T_W-1:0] v);
        mem_word_t r;
        if ((v[T_W-1:MEM_W-1] == '0) || (v[T_W-1:MEM_W-1] == '1))
        begin
            r = v[MEM_W-1:0];
        end
        else if (v[T_W-1])
        begin
            r = {1'b1, {(MEM_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(MEM_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic sample_t sat_out(input logic signed [ACC_W-1:0] v);
        sample_t r;
        if ((v[ACC_W-1:SAMPLE_BITS-1] == '0) || (v[ACC_W-1:SAMPLE_BITS-1] == '1))
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/core/idb_in_if.sv
// Input channel: two stereo frames per transaction.
interface idb_in_if;
    import idb_pkg::*;

    logic    valid;
    logic    ready;
    sample_t even_left;
    sample_t even_right;
    sample_t odd_left;
    sample_t odd_right;

    modport source (output valid, output even_left, output even_right,
                    output odd_left, output odd_right, input ready);
    modport sink   (input valid, input even_left, input even_right,
                    input odd_left, input odd_right, output ready);
endinterface

### rtl/core/idb_out_if.sv
// Output channel: one decimated stereo frame per transaction.
interface idb_out_if;
    import idb_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### rtl/core/idb_mulq.sv
// Two-stage pipelined state-by-coefficient multiplier with round-half-up scaling.
module idb_mulq (
    input  logic               clk,
    input  idb_pkg::mem_word_t  s,
    input  idb_pkg::coef_word_t c,
    output idb_pkg::prod_t      r
);
    import idb_pkg::*;

    localparam int LO_W  = MEM_W / 2;
    localparam int HI_W  = MEM_W - LO_W;
    localparam int SUM_W = MEM_W + COEF_W + 1;
    localparam logic [SUM_W-1:0] ROUND =
        {{(SUM_W - COEF_SHIFT){1'b0}}, 1'b1, {(COEF_SHIFT - 1){1'b0}}};

    logic signed [HI_W+COEF_W-1:0] p_hi_reg;
    logic signed [LO_W+COEF_W:0]   p_lo_reg;
    logic signed [SUM_W-1:0]       sum;
    prod_t                         r_reg;

    // split product: upper half signed, lower half unsigned
    always_ff @(posedge clk)
    begin
        p_hi_reg <= $signed(s[MEM_W-1:LO_W]) * c;
        p_lo_reg <= $signed({1'b0, s[LO_W-1:0]}) * c;
        r_reg    <= sum[COEF_SHIFT +: PROD_W];
    end

    assign sum = SUM_W'($signed({p_hi_reg, {LO_W{1'b0}}})) + SUM_W'(p_lo_reg)
               + $signed(ROUND);
    assign r   = r_reg;

endmodule

### rtl/core/idb_sect_mem.sv
// Section state memories (w0 and w1 per section and channel) with per-row valid bits.
module idb_sect_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  idb_pkg::mem_req_t  req,
    input  idb_pkg::mem_word_t w0_wr,
    input  idb_pkg::mem_word_t w1_wr,
    output idb_pkg::mem_word_t w0_rd,
    output idb_pkg::mem_word_t w1_rd
);
    import idb_pkg::*;

    mem_word_t       w0_mem [ROWS];
    mem_word_t       w1_mem [ROWS];
    mem_word_t       w0_rd_reg;
    mem_word_t       w1_rd_reg;
    logic [ROWS-1:0] vld_reg;
    logic            rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            w0_mem[req.wr_row] <= w0_wr;
            w1_mem[req.wr_row] <= w1_wr;
        end
        if (req.rd_en)
        begin
            w0_rd_reg <= w0_mem[req.rd_row];
            w1_rd_reg <= w1_mem[req.rd_row];
        end
    end

    // a row never written since reset or a mode change reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_row] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_row];
            end
        end
    end

    assign w0_rd = rd_vld_reg ? w0_rd_reg : '0;
    assign w1_rd = rd_vld_reg ? w1_rd_reg : '0;

endmodule

### rtl/core/iir_decimate_by_two.sv
// Top level: stereo decimate-by-two through a parallel-form elliptic IIR filter.
//
// Each input transaction carries two stereo frames and yields one stereo frame. Sections are
// processed one at a time, channel by channel, around one two-stage multiplier and the section
// memory: each section steps through a read, seven multiplies, the w1 then w0 recursion chain and a
// write-back, and input is not accepted again until the item's frame reaches the output register.
// The next item is accepted while a finished frame still waits on the output. Section state is
// zero after reset and after every quality_mode write, with no clearing pass; bias_offset applies
// from the next item. Write configuration only while the block is idle.
module iir_decimate_by_two (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [idb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [idb_pkg::CFG_DATA_W-1:0]  cfg_data,
    idb_in_if.sink                          samples,
    idb_out_if.source                       result
);
    import idb_pkg::*;

    typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_READ     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_NUM1     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_NUM2     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DEN1_W0  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DEN2_W1  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DEN2_W0  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_W1       = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DEN1_W1N = 4'd7;
    localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_WRITE    = 4'd9;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              quality_reg;
    sample_t           bias_reg;
    logic              out_valid_reg;
    sample_t           left_reg;
    sample_t           right_reg;

    sample_t                 even_reg [CHANNELS];
    sample_t                 odd_reg  [CHANNELS];
    sample_t                 y_reg    [CHANNELS];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [T_W-1:0]   t_reg;
    mem_word_t               w1n_reg;

    coef_t                     coef;
    coef_word_t                gain;
    logic [SEC_W-1:0]          last_sec;
    logic signed [SAMPLE_BITS:0] xe;
    logic signed [SAMPLE_BITS:0] xo;
    logic signed [SAMPLE_BITS:0] b2;
    logic signed [XB_W-1:0]    xbe;
    logic signed [XB_W-1:0]    xbo;
    logic signed [ACC_W-1:0]   acc_round;
    mem_word_t                 mul_s;
    coef_word_t                mul_c;
    prod_t                     mul_r;
    mem_word_t                 w0_rd;
    mem_word_t                 w1_rd;
    mem_word_t                 w0_next;
    mem_req_t                  mem_req;
    logic                      in_take;

    assign coef     = coef_rom(quality_reg, sec_reg);
    assign gain     = quality_reg ? GAIN_BEST : GAIN_FAST;
    assign last_sec = quality_reg ? SEC_W'(BEST_USED - 1) : SEC_W'(FAST_USED - 1);

    assign xe  = $signed({even_reg[ch_reg], 1'b0});
    assign xo  = $signed({odd_reg[ch_reg], 1'b0});
    assign b2  = $signed({bias_reg, 1'b0});
    assign xbe = XB_W'(xe) + XB_W'(b2);
    assign xbo = XB_W'(xo) + XB_W'(b2);

    assign acc_round = (acc_reg + ACC_W'(1)) >>> 1;
    assign w0_next   = sat_mem(t_reg - T_W'(mul_r));

    // multiplier issue schedule; each result returns through p_hi_reg/p_lo_reg and r_reg
    always_comb
    begin
        case (step_reg)
            STEP_READ:
            begin
                mul_s = MEM_W'(xe);
                mul_c = gain;
            end
            STEP_NUM1:
            begin
                mul_s = w0_rd;
                mul_c = coef.num1;
            end
            STEP_NUM2:
            begin
                mul_s = w1_rd;
                mul_c = coef.num2;
            end
            STEP_DEN1_W0:
            begin
                mul_s = w0_rd;
                mul_c = coef.den1;
            end
            STEP_DEN2_W1:
            begin
                mul_s = w1_rd;
                mul_c = coef.den2;
            end
            STEP_DEN2_W0:
            begin
                mul_s = w0_rd;
                mul_c = coef.den2;
            end
            STEP_DEN1_W1N:
            begin
                mul_s = w1n_reg;
                mul_c = coef.den1;
            end
            default:
            begin
                mul_s = w0_rd;
                mul_c = coef.num1;
            end
        endcase
    end

    assign mem_req.rd_en  = (state_reg == RUN) && (step_reg == STEP_READ);
    assign mem_req.rd_row = row_reg;
    assign mem_req.wr_en  = (state_reg == RUN) && (step_reg == STEP_WRITE);
    assign mem_req.wr_row = row_reg;
    assign mem_req.clear  = cfg_write && (cfg_index == REG_QUALITY);

    idb_mulq u_mulq (
        .clk (clk),
        .s   (mul_s),
        .c   (mul_c),
        .r   (mul_r)
    );

    idb_sect_mem u_sect_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .w0_wr (w0_next),
        .w1_wr (w1n_reg),
        .w0_rd (w0_rd),
        .w1_rd (w1_rd)
    );

    assign samples.ready    = (state_reg == IDLE);
    assign in_take          = samples.valid && samples.ready;
    assign result.valid     = out_valid_reg;
    assign result.left_out  = left_reg;
    assign result.right_out = right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            step_reg      <= STEP_READ;
            sec_reg       <= '0;
            ch_reg        <= '0;
            row_reg       <= '0;
            quality_reg   <= 1'b1;
            bias_reg      <= '0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_QUALITY: quality_reg <= cfg_data[0];
                    REG_BIAS:    bias_reg    <= cfg_data[SAMPLE_BITS-1:0];
                    default:     ;
                endcase
            end
            // in FIN the output register is reloaded below instead
            if (result.valid && result.ready && (state_reg != FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (samples.valid)
                    begin
                        state_reg <= RUN;
                        step_reg  <= STEP_READ;
                        sec_reg   <= '0;
                        ch_reg    <= '0;
                        row_reg   <= '0;
                    end
                end
                RUN:
                begin
                    if (step_reg == STEP_WRITE)
                    begin
                        step_reg <= STEP_READ;
                        row_reg  <= row_reg + ROW_W'(1);
                        if (sec_reg == last_sec)
                        begin
                            sec_reg <= '0;
                            if (ch_reg == CH_W'(CHANNELS - 1))
                            begin
                                state_reg <= FIN;
                            end
                            else
                            begin
                                ch_reg <= ch_reg + CH_W'(1);
                            end
                        end
                        else
                        begin
                            sec_reg <= sec_reg + SEC_W'(1);
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                FIN:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        left_reg      <= y_reg[0];
                        right_reg     <= y_reg[1];
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            even_reg[0] <= samples.even_left;
            even_reg[1] <= samples.even_right;
            odd_reg[0]  <= samples.odd_left;
            odd_reg[1]  <= samples.odd_right;
        end
        if (state_reg == RUN)
        begin
            case (step_reg)
                STEP_NUM2:
                begin
                    // gain term opens the channel's sum
                    if (sec_reg == '0)
                    begin
                        acc_reg <= ACC_W'(mul_r);
                    end
                end
                STEP_DEN1_W0:  acc_reg <= acc_reg + ACC_W'(mul_r);
                STEP_DEN2_W1:  acc_reg <= acc_reg + ACC_W'(mul_r);
                STEP_DEN2_W0:  t_reg   <= T_W'(xbe) - T_W'(mul_r);
                STEP_W1:       w1n_reg <= sat_mem(t_reg - T_W'(mul_r));
                STEP_DEN1_W1N: t_reg   <= T_W'(xbo) - T_W'(mul_r);
                STEP_WRITE:
                begin
                    if (sec_reg == last_sec)
                    begin
                        y_reg[ch_reg] <= sat_out(acc_round);
                    end
                end
                default: ;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("input accepted while an item was in flight");

    a_write_matches_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> $past(mem_req.rd_en, 9) && ($past(mem_req.rd_row, 9) == mem_req.wr_row))
        else $error("section write-back does not match the row read nine cycles earlier");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == FIN)
        else $error("output became valid outside the finish state");

    a_section_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == RUN |-> sec_reg <= last_sec)
        else $error("section counter beyond the table length");

endmodule
